// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same, for checks that must also hold during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/gqod_pkg.sv -----
// Shared types, Bayer matrices and threshold helpers for the gamma dither block.
package gqod_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned TABLE_AW    = 8;

  // Supported matrix orders
  localparam logic [3:0] ORDER_2 = 4'd2;
  localparam logic [3:0] ORDER_3 = 4'd3;
  localparam logic [3:0] ORDER_4 = 4'd4;
  localparam logic [3:0] ORDER_8 = 4'd8;

  // Register select (paddr bit 2)
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // tuser bit 0
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_LOAD  = 1'b1;

  // Bound that no 8-bit value reaches: output stays 0
  localparam logic [8:0] BOUND_NEVER = 9'h1FF;

  localparam logic [5:0] BAYER2 [4] = '{6'd0, 6'd2, 6'd3, 6'd1};
  localparam logic [5:0] BAYER3 [9] = '{6'd6, 6'd8, 6'd4, 6'd1, 6'd0, 6'd3,
                                        6'd5, 6'd2, 6'd7};
  localparam logic [5:0] BAYER4 [16] = '{
    6'd0,  6'd8,  6'd2,  6'd10, 6'd12, 6'd4,  6'd14, 6'd6,
    6'd3,  6'd11, 6'd1,  6'd9,  6'd15, 6'd7,  6'd13, 6'd5
  };
  localparam logic [5:0] BAYER8 [64] = '{
    6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
    6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
    6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
    6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
    6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
    6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
    6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
    6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
  };

  typedef struct packed {
    logic step;  // pixel beat accepted
    logic sof;   // first pixel of frame
  } pos_cmd_t;

  function automatic logic order_ok(input logic [3:0] n);
    return (n == ORDER_2) || (n == ORDER_3) || (n == ORDER_4) || (n == ORDER_8);
  endfunction

  // p mod n for p in 0..8; any order not 2/3/4 wraps at 8
  function automatic logic [2:0] phase_mod(input logic [3:0] p, input logic [3:0] n);
    logic [3:0] r;
    r = p;
    case (n)
      ORDER_2: r = {3'b000, p[0]};
      ORDER_3: begin
        if (p >= 4'd6) r = p - 4'd6;
        else if (p >= 4'd3) r = p - 4'd3;
        else r = p;
      end
      ORDER_4: r = {2'b00, p[1:0]};
      default: r = {1'b0, p[2:0]};
    endcase
    return r[2:0];
  endfunction

  function automatic logic [5:0] bayer_at(input logic [3:0] n, input logic [2:0] c,
                                          input logic [2:0] r);
    logic [3:0] i3;
    logic [5:0] t;
    i3 = 4'(c) * 4'd3 + 4'(r);
    case (n)
      ORDER_2: t = BAYER2[{c[0], r[0]}];
      ORDER_3: t = BAYER3[i3];
      ORDER_4: t = BAYER4[{c[1:0], r[1:0]}];
      default: t = BAYER8[{c, r}];
    endcase
    return t;
  endfunction

  // floor(g/scale) > t  <=>  g >= (t+1)*scale
  function automatic logic [8:0] bound_of(input logic [3:0] n, input logic [5:0] t);
    logic [8:0] tp1;
    logic [8:0] b;
    tp1 = 9'(t) + 9'd1;
    case (n)
      ORDER_2: b = tp1 << 6;
      ORDER_3: b = tp1 * 9'd28;
      ORDER_4: b = tp1 << 4;
      ORDER_8: b = tp1 << 2;
      default: b = BOUND_NEVER;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/gamma_quantize_ordered_dither.sv -----
// Gamma lookup and ordered Bayer dither of a grey pixel stream, top level.
//
// Slave stream: tuser[0] selects the beat kind (0 pixel, 1 gamma table load),
// tuser[1] flags the first pixel of a frame and clears the column/row
// position. tdata carries pixel, table index and table entry. A load writes
// one entry of the 256-entry gamma memory and gives no output beat; every
// pixel beat gives exactly one master beat with tdata 0 or 255.
// The gamma table must be loaded before pixels that read it.
// Throughput: one beat per cycle, pixels and loads alike, while the receiver
// does not stall. A pixel passes the synchronous gamma memory read and then
// the output register before it is presented on the master side.
// A load followed at once by a pixel at the same entry sees the new value.
// When the receiver stalls, the output register and the read stage fill and
// s_axis_tready drops; nothing is lost or repeated.
// Reset clears the pipeline, the position counters and the registers
// (matrix order 4, image width 640); the gamma memory is not cleared.
// APB: 0x0 matrix order, 0x4 image width; write only while the stream is idle.
`include "assert_macros.svh"

module gamma_quantize_ordered_dither #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] pixel, [15:8] table_index, [23:16] table_entry
  input  logic [1:0]  s_axis_tuser,  // [0] action, [1] start_of_frame
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_pixel
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  order_q;
  logic [12:0] width_q;
  logic        cfg_wr;

  logic        in_acc, pix_acc, ld_acc;
  logic        s1_valid_q, s1_valid_d, s1_move;
  logic [8:0]  s1_bound_q, bound;
  logic [7:0]  rdata_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q;

  logic [7:0]  gamma_mem [gqod_pkg::TABLE_DEPTH];

  gqod_pkg::pos_cmd_t pos_cmd;

  // ---------------- config ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= gqod_pkg::ORDER_4;
      width_q <= 13'd640;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        gqod_pkg::REG_ORDER: order_q <= pwdata[3:0];
        gqod_pkg::REG_WIDTH: width_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gqod_pkg::REG_ORDER: prdata = 32'(order_q);
      gqod_pkg::REG_WIDTH: prdata = 32'(width_q);
      default:             prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pix_acc       = in_acc && (s_axis_tuser[0] == gqod_pkg::ACT_PIXEL);
  assign ld_acc        = in_acc && (s_axis_tuser[0] == gqod_pkg::ACT_LOAD);

  assign pos_cmd.step = pix_acc;
  assign pos_cmd.sof  = s_axis_tuser[1];

  gqod_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .order_i (order_q),
    .width_i (width_q),
    .cmd_i   (pos_cmd),
    .bound_o (bound)
  );

  // ---------------- gamma memory ----------------
  // Loads and pixel reads never share a cycle, so a read always sees
  // every earlier write.
  always_ff @(posedge clk_i) begin
    if (ld_acc) begin
      gamma_mem[s_axis_tdata[15:8]] <= s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      rdata_q    <= gamma_mem[s_axis_tdata[7:0]];
      s1_bound_q <= bound;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= ({1'b0, rdata_q} >= s1_bound_q) ? 8'hFF : 8'h00;
    end
  end

  // ---------------- pipeline valids ----------------
  always_comb begin
    priority if (pix_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    priority if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- assertions ----------------
  `ASSERT_CLK(a_ready_when_empty, clk_i, rst_ni, !s1_valid_q |-> s_axis_tready, "stage empty but not ready")
  `ASSERT_CLK(a_pixel_enters, clk_i, rst_ni, pix_acc |=> s1_valid_q, "accepted pixel lost")
  `ASSERT_CLK(a_load_no_result, clk_i, rst_ni, ld_acc |=> !s1_valid_q, "load beat produced a result")
  `ASSERT_CLK(a_binary_out, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata == 8'h00 || m_axis_tdata == 8'hFF), "output not 0 or 255")

endmodule

// ----- rtl/gqod_pos.sv -----
// Raster position counters and per-pixel dither threshold.
module gqod_pos #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        order_i,
  input  logic [12:0]       width_i,
  input  gqod_pkg::pos_cmd_t cmd_i,
  output logic [8:0]        bound_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = (CW + 1 > 13) ? CW + 1 : 13;

  logic [CW-1:0] cc_q, cc_d, cc_cur;
  logic [2:0]    cp_q, cp_d, cp_cur;
  logic [2:0]    rp_q, rp_d, rp_cur;
  logic [WW-1:0] img_w, eff_w, cc_next_w;
  logic [3:0]    mod_n;
  logic [2:0]    c_idx, r_idx;

  assign cc_cur = cmd_i.sof ? '0 : cc_q;
  assign cp_cur = cmd_i.sof ? '0 : cp_q;
  assign rp_cur = cmd_i.sof ? '0 : rp_q;

  assign mod_n = gqod_pkg::order_ok(order_i) ? order_i : gqod_pkg::ORDER_8;

  // Threshold lookup reduces a stale phase modulo the current order
  assign c_idx   = gqod_pkg::phase_mod(4'(cp_cur), order_i);
  assign r_idx   = gqod_pkg::phase_mod(4'(rp_cur), order_i);
  assign bound_o = gqod_pkg::bound_of(order_i, gqod_pkg::bayer_at(order_i, c_idx, r_idx));

  // Width zero acts as one, larger than MAX_WIDTH saturates
  assign img_w     = WW'(width_i);
  assign cc_next_w = WW'(cc_cur) + WW'(1);

  always_comb begin
    priority if (img_w == '0) begin
      eff_w = WW'(1);
    end else if (img_w > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = img_w;
    end
  end

  always_comb begin
    cc_d = cc_q;
    cp_d = cp_q;
    rp_d = rp_q;
    if (cmd_i.step) begin
      if (cc_next_w >= eff_w) begin
        cc_d = '0;
        cp_d = '0;
        rp_d = gqod_pkg::phase_mod(
                 4'(gqod_pkg::phase_mod(4'(rp_cur), mod_n)) + 4'd1, mod_n);
      end else begin
        cc_d = cc_next_w[CW-1:0];
        cp_d = gqod_pkg::phase_mod(
                 4'(gqod_pkg::phase_mod(4'(cp_cur), mod_n)) + 4'd1, mod_n);
        rp_d = rp_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= '0;
      cp_q <= '0;
      rp_q <= '0;
    end else begin
      cc_q <= cc_d;
      cp_q <= cp_d;
      rp_q <= rp_d;
    end
  end

endmodule
